// ===== sv/fdr_pkg.sv =====
// ----------------------------------------------------------------------------
// fdr_pkg
// Shared constants, types and helper functions for the frame store refresh unit.
// ----------------------------------------------------------------------------
package fdr_pkg;

  localparam int SCREEN_WIDTH      = 128;
  localparam int SCREEN_HEIGHT     = 128;
  localparam int PIXELS_PER_RESULT = 4;

  localparam int PIX_W     = 16;
  localparam int COORD_W   = 9;
  localparam int OUT_ROW_W = 7;
  localparam int COL_W     = $clog2(SCREEN_WIDTH);
  localparam int ROW_W     = (SCREEN_HEIGHT > 1) ? $clog2(SCREEN_HEIGHT) : 1;
  localparam int FS_DEPTH  = SCREEN_WIDTH * SCREEN_HEIGHT;
  localparam int ADDR_W    = $clog2(FS_DEPTH);
  localparam int CNT_W     = $clog2(SCREEN_WIDTH + PIXELS_PER_RESULT + 1);
  localparam int SPAN_W    =
    $clog2(((SCREEN_WIDTH > SCREEN_HEIGHT) ? SCREEN_WIDTH : SCREEN_HEIGHT) + 1);
  localparam int SLOT_W    = (PIXELS_PER_RESULT > 1) ? $clog2(PIXELS_PER_RESULT) : 1;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'h1021;

  typedef enum logic [2:0] {
    ACT_PIXEL   = 3'd0,
    ACT_HLINE   = 3'd1,
    ACT_VLINE   = 3'd2,
    ACT_FILL    = 3'd3,
    ACT_READ    = 3'd4,
    ACT_REFRESH = 3'd5
  } action_t;

  typedef enum logic {
    KIND_READ = 1'b0,
    KIND_ROW  = 1'b1
  } kind_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_LINE,
    ST_CRC_RD,
    ST_CRC_HI,
    ST_CRC_LO,
    ST_CRC_CMP,
    ST_EM_RD,
    ST_WAIT,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [PIX_W-1:0]  wdata;
    logic              re;
    logic [ADDR_W-1:0] raddr;
  } fs_req_t;

  typedef struct packed {
    logic             we;
    logic [ROW_W-1:0] waddr;
    logic [15:0]      wdata;
    logic             re;
    logic [ROW_W-1:0] raddr;
  } cks_req_t;

  function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
    logic [15:0] c;
    c = crc_in ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

  function automatic logic [ADDR_W-1:0] pix_addr(input logic [ROW_W-1:0] r,
                                                 input logic [COL_W-1:0] c);
    return ADDR_W'(r) * ADDR_W'(SCREEN_WIDTH) + ADDR_W'(c);
  endfunction

endpackage

// ===== sv/fdr_ram.sv =====
// ----------------------------------------------------------------------------
// fdr_ram
// Generic single-write, single-read synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
module fdr_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                                       clk,
  input  logic                                       we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                           wdata,
  input  logic                                       re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                           rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== sv/fdr_ctrl.sv =====
// ----------------------------------------------------------------------------
// fdr_ctrl
// Sequencer for drawing, fill, pixel read and row refresh over the frame store.
// ----------------------------------------------------------------------------
module fdr_ctrl (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic                           cfg_data,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [2:0]                     action,
  input  logic signed [fdr_pkg::COORD_W-1:0] col_start,
  input  logic signed [fdr_pkg::COORD_W-1:0] col_end,
  input  logic signed [fdr_pkg::COORD_W-1:0] row_start,
  input  logic signed [fdr_pkg::COORD_W-1:0] row_end,
  input  logic [fdr_pkg::PIX_W-1:0]      color,
  input  logic                           xor_mode,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic                           kind,
  output logic [fdr_pkg::OUT_ROW_W-1:0]  row,
  output logic [fdr_pkg::PIX_W-1:0]      pixel_a,
  output logic [fdr_pkg::PIX_W-1:0]      pixel_b,
  output logic [fdr_pkg::PIX_W-1:0]      pixel_c,
  output logic [fdr_pkg::PIX_W-1:0]      pixel_d,
  output logic                           last,
  output fdr_pkg::fs_req_t               fs_req,
  input  logic [fdr_pkg::PIX_W-1:0]      fs_rdata,
  output fdr_pkg::cks_req_t              cks_req,
  input  logic [15:0]                    cks_rdata
);

  localparam logic signed [9:0] W_LAST = 10'(fdr_pkg::SCREEN_WIDTH - 1);
  localparam logic signed [9:0] H_LAST = 10'(fdr_pkg::SCREEN_HEIGHT - 1);

  fdr_pkg::state_t state, state_next;

  logic                              partial_mode;
  logic [fdr_pkg::PIX_W-1:0]         color_r;
  logic                              xor_r;
  logic                              vert_r;
  logic [fdr_pkg::ROW_W-1:0]         row_r;
  logic [fdr_pkg::COL_W-1:0]         fix_col;
  logic [fdr_pkg::SPAN_W-1:0]        cur;
  logic [fdr_pkg::SPAN_W-1:0]        hi_r;
  logic                              pend_line;
  logic [fdr_pkg::ADDR_W-1:0]        pend_addr;
  logic [fdr_pkg::CNT_W-1:0]         col_r;
  logic [fdr_pkg::SLOT_W-1:0]        slot;
  logic [15:0]                       crc_r;
  logic [7:0]                        lo_byte;
  logic                              pend_v;
  logic [fdr_pkg::SLOT_W-1:0]        pend_slot;
  logic                              pend_zero;
  logic [fdr_pkg::PIX_W-1:0]         pix [4];
  logic                              res_kind;
  logic [fdr_pkg::OUT_ROW_W-1:0]     res_row;
  logic [fdr_pkg::ADDR_W-1:0]        clr_cnt;
  logic                              clr_cks;

  logic signed [9:0] c0, c1, r0, r1;
  logic signed [9:0] h_lo, h_hi, v_lo, v_hi, h_lo_c, h_hi_c, v_lo_c, v_hi_c;
  logic              c_on, r_on, h_draw, v_draw, in_fire, out_load;
  logic              line_issue, line_done, crc_end, em_last, em_zero;
  logic [fdr_pkg::CNT_W-1:0]  em_col;
  logic [fdr_pkg::ADDR_W-1:0] line_addr;
  logic [fdr_pkg::PIX_W-1:0]  line_wdata;

  // Coordinate decode and clipping.
  assign c0 = {col_start[8], col_start};
  assign c1 = {col_end[8], col_end};
  assign r0 = {row_start[8], row_start};
  assign r1 = {row_end[8], row_end};
  assign c_on = (c0 >= 10'sd0) && (c0 <= W_LAST);
  assign r_on = (r0 >= 10'sd0) && (r0 <= H_LAST);
  assign h_lo = (c0 < c1) ? c0 : c1;
  assign h_hi = (c0 < c1) ? c1 : c0;
  assign v_lo = (r0 < r1) ? r0 : r1;
  assign v_hi = (r0 < r1) ? r1 : r0;
  assign h_lo_c = (h_lo < 10'sd0) ? 10'sd0 : h_lo;
  assign h_hi_c = (h_hi > W_LAST) ? W_LAST : h_hi;
  assign v_lo_c = (v_lo < 10'sd0) ? 10'sd0 : v_lo;
  assign v_hi_c = (v_hi > H_LAST) ? H_LAST : v_hi;
  assign h_draw = r_on && (h_lo_c <= h_hi_c);
  assign v_draw = c_on && (v_lo_c <= v_hi_c);

  assign in_fire  = in_valid && in_ready;
  assign out_load = (state == fdr_pkg::ST_OUT) && (!out_valid || out_ready);

  assign line_issue = (cur <= hi_r);
  assign line_done  = !line_issue && !pend_line;
  assign line_addr  = vert_r ? fdr_pkg::pix_addr(fdr_pkg::ROW_W'(cur), fix_col)
                             : fdr_pkg::pix_addr(row_r, fdr_pkg::COL_W'(cur));
  assign line_wdata = (xor_r && (fs_rdata == color_r)) ? ~color_r : color_r;

  assign crc_end = (col_r == fdr_pkg::CNT_W'(fdr_pkg::SCREEN_WIDTH - 1));
  assign em_col  = col_r + fdr_pkg::CNT_W'(slot);
  assign em_zero = (em_col >= fdr_pkg::CNT_W'(fdr_pkg::SCREEN_WIDTH));
  assign em_last = ((col_r + fdr_pkg::CNT_W'(fdr_pkg::PIXELS_PER_RESULT))
                    >= fdr_pkg::CNT_W'(fdr_pkg::SCREEN_WIDTH));

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      fdr_pkg::ST_IDLE: begin
        if (in_fire) begin
          case (action)
            fdr_pkg::ACT_HLINE:   if (h_draw) state_next = fdr_pkg::ST_LINE;
            fdr_pkg::ACT_VLINE:   if (v_draw) state_next = fdr_pkg::ST_LINE;
            fdr_pkg::ACT_FILL:    state_next = fdr_pkg::ST_CLEAR;
            fdr_pkg::ACT_READ:    state_next = fdr_pkg::ST_WAIT;
            fdr_pkg::ACT_REFRESH: begin
              if (r_on) begin
                state_next = partial_mode ? fdr_pkg::ST_CRC_RD : fdr_pkg::ST_EM_RD;
              end
            end
            default: state_next = fdr_pkg::ST_IDLE;
          endcase
        end
      end
      fdr_pkg::ST_CLEAR: begin
        if (clr_cnt == fdr_pkg::ADDR_W'(fdr_pkg::FS_DEPTH - 1)) state_next = fdr_pkg::ST_IDLE;
      end
      fdr_pkg::ST_LINE:   if (line_done) state_next = fdr_pkg::ST_IDLE;
      fdr_pkg::ST_CRC_RD: state_next = fdr_pkg::ST_CRC_HI;
      fdr_pkg::ST_CRC_HI: state_next = fdr_pkg::ST_CRC_LO;
      fdr_pkg::ST_CRC_LO: state_next = crc_end ? fdr_pkg::ST_CRC_CMP : fdr_pkg::ST_CRC_HI;
      fdr_pkg::ST_CRC_CMP: begin
        state_next = (crc_r == cks_rdata) ? fdr_pkg::ST_IDLE : fdr_pkg::ST_EM_RD;
      end
      fdr_pkg::ST_EM_RD: begin
        if (slot == fdr_pkg::SLOT_W'(fdr_pkg::PIXELS_PER_RESULT - 1)) begin
          state_next = fdr_pkg::ST_WAIT;
        end
      end
      fdr_pkg::ST_WAIT: state_next = fdr_pkg::ST_OUT;
      fdr_pkg::ST_OUT: begin
        if (out_load) begin
          state_next = (res_kind && !em_last) ? fdr_pkg::ST_EM_RD : fdr_pkg::ST_IDLE;
        end
      end
      default: state_next = fdr_pkg::ST_IDLE;
    endcase
  end

  // Memory requests and handshake outputs.
  always_comb begin
    fs_req  = '0;
    cks_req = '0;
    in_ready = (state == fdr_pkg::ST_IDLE);
    case (state)
      fdr_pkg::ST_IDLE: begin
        if (in_fire && c_on && r_on) begin
          if (action == fdr_pkg::ACT_PIXEL) begin
            fs_req.we    = 1'b1;
            fs_req.waddr = fdr_pkg::pix_addr(fdr_pkg::ROW_W'(r0), fdr_pkg::COL_W'(c0));
            fs_req.wdata = color;
          end else if (action == fdr_pkg::ACT_READ) begin
            fs_req.re    = 1'b1;
            fs_req.raddr = fdr_pkg::pix_addr(fdr_pkg::ROW_W'(r0), fdr_pkg::COL_W'(c0));
          end
        end
      end
      fdr_pkg::ST_CLEAR: begin
        fs_req.we     = 1'b1;
        fs_req.waddr  = clr_cnt;
        fs_req.wdata  = color_r;
        cks_req.we    = clr_cks && (clr_cnt < fdr_pkg::ADDR_W'(fdr_pkg::SCREEN_HEIGHT));
        cks_req.waddr = clr_cnt[fdr_pkg::ROW_W-1:0];
        cks_req.wdata = '0;
      end
      fdr_pkg::ST_LINE: begin
        fs_req.re    = line_issue;
        fs_req.raddr = line_addr;
        fs_req.we    = pend_line;
        fs_req.waddr = pend_addr;
        fs_req.wdata = line_wdata;
      end
      fdr_pkg::ST_CRC_RD: begin
        fs_req.re     = 1'b1;
        fs_req.raddr  = fdr_pkg::pix_addr(row_r, '0);
        cks_req.re    = 1'b1;
        cks_req.raddr = row_r;
      end
      fdr_pkg::ST_CRC_LO: begin
        fs_req.re    = !crc_end;
        fs_req.raddr = fdr_pkg::pix_addr(row_r, fdr_pkg::COL_W'(col_r + 1'b1));
      end
      fdr_pkg::ST_CRC_CMP: begin
        cks_req.we    = (crc_r != cks_rdata);
        cks_req.waddr = row_r;
        cks_req.wdata = crc_r;
      end
      fdr_pkg::ST_EM_RD: begin
        fs_req.re    = !em_zero;
        fs_req.raddr = fdr_pkg::pix_addr(row_r, fdr_pkg::COL_W'(em_col));
      end
      default: begin
        fs_req  = '0;
        cks_req = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= fdr_pkg::ST_CLEAR;
      partial_mode <= 1'b1;
      clr_cnt      <= '0;
      clr_cks      <= 1'b1;
      color_r      <= '0;
      pend_line    <= 1'b0;
      pend_v       <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) partial_mode <= cfg_data;
      pend_v    <= 1'b0;
      pend_line <= 1'b0;

      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end

      case (state)
        fdr_pkg::ST_IDLE: begin
          if (in_fire) begin
            color_r  <= color;
            xor_r    <= xor_mode;
            vert_r   <= (action == fdr_pkg::ACT_VLINE);
            row_r    <= fdr_pkg::ROW_W'(r0);
            fix_col  <= fdr_pkg::COL_W'(c0);
            res_row  <= (action == fdr_pkg::ACT_READ && !(c_on && r_on)) ? '0 : r0[6:0];
            res_kind <= (action == fdr_pkg::ACT_REFRESH);
            col_r    <= '0;
            slot     <= '0;
            crc_r    <= fdr_pkg::CRC_INIT;
            clr_cnt  <= '0;
            clr_cks  <= 1'b0;
            for (int i = 0; i < 4; i++) pix[i] <= '0;
            if (action == fdr_pkg::ACT_VLINE) begin
              cur  <= fdr_pkg::SPAN_W'(v_lo_c);
              hi_r <= fdr_pkg::SPAN_W'(v_hi_c);
            end else begin
              cur  <= fdr_pkg::SPAN_W'(h_lo_c);
              hi_r <= fdr_pkg::SPAN_W'(h_hi_c);
            end
            if (action == fdr_pkg::ACT_READ && c_on && r_on) begin
              pend_v    <= 1'b1;
              pend_slot <= '0;
              pend_zero <= 1'b0;
            end
          end
        end
        fdr_pkg::ST_CLEAR: clr_cnt <= clr_cnt + 1'b1;
        fdr_pkg::ST_LINE: begin
          pend_line <= line_issue;
          pend_addr <= line_addr;
          if (line_issue) cur <= cur + 1'b1;
        end
        fdr_pkg::ST_CRC_HI: begin
          crc_r   <= fdr_pkg::crc_byte(crc_r, fs_rdata[15:8]);
          lo_byte <= fs_rdata[7:0];
        end
        fdr_pkg::ST_CRC_LO: begin
          crc_r <= fdr_pkg::crc_byte(crc_r, lo_byte);
          col_r <= crc_end ? '0 : col_r + 1'b1;
        end
        fdr_pkg::ST_EM_RD: begin
          pend_v    <= 1'b1;
          pend_slot <= slot;
          pend_zero <= em_zero;
          slot      <= slot + 1'b1;
        end
        fdr_pkg::ST_OUT: begin
          if (out_load) begin
            kind    <= res_kind;
            row     <= res_row;
            pixel_a <= pix[0];
            pixel_b <= pix[1];
            pixel_c <= pix[2];
            pixel_d <= pix[3];
            last    <= !res_kind || em_last;
            col_r   <= col_r + fdr_pkg::CNT_W'(fdr_pkg::PIXELS_PER_RESULT);
            slot    <= '0;
            for (int i = 0; i < 4; i++) pix[i] <= '0;
          end
        end
        default: begin
        end
      endcase

      // Read data lands in the cycle after the request.
      if (pend_v) begin
        pix[pend_slot] <= pend_zero ? '0 : fs_rdata;
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_pend_after_read: assert property (@(posedge clk) disable iff (rst)
    pend_v |-> $past(fs_req.re) || $past(state == fdr_pkg::ST_EM_RD))
    else $error("pixel capture without a preceding read");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (state == fdr_pkg::ST_OUT && out_valid && !out_ready) |=> state == fdr_pkg::ST_OUT)
    else $error("result group left while output was stalled");
  a_line_write: assert property (@(posedge clk) disable iff (rst)
    (state == fdr_pkg::ST_LINE && fs_req.we) |-> pend_line)
    else $error("line write without pending read");
  a_read_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && kind == fdr_pkg::KIND_READ) |-> last)
    else $error("pixel read result not marked last");
`endif

endmodule

// ===== sv/framebuffer_dirty_row_refresh_unit.sv =====
// ----------------------------------------------------------------------------
// framebuffer_dirty_row_refresh_unit
// Pixel and line draw: a pixel is written as the request is taken; a line reads and
// rewrites each pixel of its clipped span. Fill writes all W*H frame entries; read
// passes the pixel to the output register. Partial refresh first runs a checksum pass
// over the single read port, then emits result groups; full refresh skips the checksum.
// After reset a clearing pass over all W*H entries zeroes the frame and row checksums.
// ----------------------------------------------------------------------------
module framebuffer_dirty_row_refresh_unit (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic                               cfg_data,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [2:0]                         action,
  input  logic signed [fdr_pkg::COORD_W-1:0] col_start,
  input  logic signed [fdr_pkg::COORD_W-1:0] col_end,
  input  logic signed [fdr_pkg::COORD_W-1:0] row_start,
  input  logic signed [fdr_pkg::COORD_W-1:0] row_end,
  input  logic [fdr_pkg::PIX_W-1:0]          color,
  input  logic                               xor_mode,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic                               kind,
  output logic [fdr_pkg::OUT_ROW_W-1:0]      row,
  output logic [fdr_pkg::PIX_W-1:0]          pixel_a,
  output logic [fdr_pkg::PIX_W-1:0]          pixel_b,
  output logic [fdr_pkg::PIX_W-1:0]          pixel_c,
  output logic [fdr_pkg::PIX_W-1:0]          pixel_d,
  output logic                               last
);

  fdr_pkg::fs_req_t          fs_req;
  fdr_pkg::cks_req_t         cks_req;
  logic [fdr_pkg::PIX_W-1:0] fs_rdata;
  logic [15:0]               cks_rdata;

  fdr_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .action    (action),
    .col_start (col_start),
    .col_end   (col_end),
    .row_start (row_start),
    .row_end   (row_end),
    .color     (color),
    .xor_mode  (xor_mode),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .kind      (kind),
    .row       (row),
    .pixel_a   (pixel_a),
    .pixel_b   (pixel_b),
    .pixel_c   (pixel_c),
    .pixel_d   (pixel_d),
    .last      (last),
    .fs_req    (fs_req),
    .fs_rdata  (fs_rdata),
    .cks_req   (cks_req),
    .cks_rdata (cks_rdata)
  );

  fdr_ram #(
    .WIDTH (fdr_pkg::PIX_W),
    .DEPTH (fdr_pkg::FS_DEPTH)
  ) u_frame_ram (
    .clk   (clk),
    .we    (fs_req.we),
    .waddr (fs_req.waddr),
    .wdata (fs_req.wdata),
    .re    (fs_req.re),
    .raddr (fs_req.raddr),
    .rdata (fs_rdata)
  );

  fdr_ram #(
    .WIDTH (16),
    .DEPTH (fdr_pkg::SCREEN_HEIGHT)
  ) u_cks_ram (
    .clk   (clk),
    .we    (cks_req.we),
    .waddr (cks_req.waddr),
    .wdata (cks_req.wdata),
    .re    (cks_req.re),
    .raddr (cks_req.raddr),
    .rdata (cks_rdata)
  );

endmodule

// ===== tb/framebuffer_dirty_row_refresh_unit_chk.sv =====
// ----------------------------------------------------------------------------
// Frame store refresh checker
// Watches the request and result channels, keeps its own copy of the frame
// and of the row checksums, and compares every result with the prediction.
// ----------------------------------------------------------------------------
module framebuffer_dirty_row_refresh_unit_chk (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic                               cfg_data,
  input  logic                               in_valid,
  input  logic                               in_ready,
  input  logic [2:0]                         action,
  input  logic signed [fdr_pkg::COORD_W-1:0] col_start,
  input  logic signed [fdr_pkg::COORD_W-1:0] col_end,
  input  logic signed [fdr_pkg::COORD_W-1:0] row_start,
  input  logic signed [fdr_pkg::COORD_W-1:0] row_end,
  input  logic [fdr_pkg::PIX_W-1:0]          color,
  input  logic                               xor_mode,
  input  logic                               out_valid,
  input  logic                               out_ready,
  input  logic                               kind,
  input  logic [fdr_pkg::OUT_ROW_W-1:0]      row,
  input  logic [fdr_pkg::PIX_W-1:0]          pixel_a,
  input  logic [fdr_pkg::PIX_W-1:0]          pixel_b,
  input  logic [fdr_pkg::PIX_W-1:0]          pixel_c,
  input  logic [fdr_pkg::PIX_W-1:0]          pixel_d,
  input  logic                               last,
  output int                                 fail_count,
  output int                                 pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic                          kind;
    logic [fdr_pkg::OUT_ROW_W-1:0] row;
    logic [fdr_pkg::PIX_W-1:0]     pa, pb, pc, pd;
    logic                          last;
  } group_t;

  logic [fdr_pkg::PIX_W-1:0] frame [fdr_pkg::FS_DEPTH];
  logic [15:0]               row_sums [fdr_pkg::SCREEN_HEIGHT];
  logic                      partial;
  group_t                    expected_groups [$];

  initial pending = 0;

  task automatic report(input string what, input logic [15:0] got, input logic [15:0] want);
    $display("mismatch at %0t: %s got %h expected %h", $realtime, what, got, want);
    fail_count++;
  endtask

  function automatic logic [15:0] crc8(input logic [15:0] c_in, input logic [7:0] b);
    logic [15:0] c;
    c = c_in ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) c = c[15] ? ((c << 1) ^ 16'h1021) : (c << 1);
    return c;
  endfunction

  function automatic void plot(input int c, input int r, input logic [15:0] clr,
                               input logic xr);
    int a;
    a = r * fdr_pkg::SCREEN_WIDTH + c;
    frame[a] = (xr && frame[a] == clr) ? ~clr : clr;
  endfunction

  function automatic void predict_request(input logic [2:0] op, input int c0, input int c1,
                                          input int r0, input int r1,
                                          input logic [15:0] clr, input logic xr);
    int lo, hi;
    logic [15:0] sum;
    group_t g;
    case (op)
      fdr_pkg::ACT_PIXEL: begin
        if (c0 >= 0 && c0 < fdr_pkg::SCREEN_WIDTH && r0 >= 0 && r0 < fdr_pkg::SCREEN_HEIGHT)
          frame[r0 * fdr_pkg::SCREEN_WIDTH + c0] = clr;
      end
      fdr_pkg::ACT_HLINE: begin
        if (r0 >= 0 && r0 < fdr_pkg::SCREEN_HEIGHT) begin
          lo = (c0 < c1) ? c0 : c1;
          hi = (c0 < c1) ? c1 : c0;
          if (lo < 0) lo = 0;
          if (hi > fdr_pkg::SCREEN_WIDTH - 1) hi = fdr_pkg::SCREEN_WIDTH - 1;
          for (int k = lo; k <= hi; k++) plot(k, r0, clr, xr);
        end
      end
      fdr_pkg::ACT_VLINE: begin
        if (c0 >= 0 && c0 < fdr_pkg::SCREEN_WIDTH) begin
          lo = (r0 < r1) ? r0 : r1;
          hi = (r0 < r1) ? r1 : r0;
          if (lo < 0) lo = 0;
          if (hi > fdr_pkg::SCREEN_HEIGHT - 1) hi = fdr_pkg::SCREEN_HEIGHT - 1;
          for (int k = lo; k <= hi; k++) plot(c0, k, clr, xr);
        end
      end
      fdr_pkg::ACT_FILL: begin
        foreach (frame[i]) frame[i] = clr;
      end
      fdr_pkg::ACT_READ: begin
        g = '0;
        g.kind = fdr_pkg::KIND_READ;
        g.last = 1'b1;
        if (c0 >= 0 && c0 < fdr_pkg::SCREEN_WIDTH && r0 >= 0 && r0 < fdr_pkg::SCREEN_HEIGHT)
        begin
          g.row = r0[fdr_pkg::OUT_ROW_W-1:0];
          g.pa = frame[r0 * fdr_pkg::SCREEN_WIDTH + c0];
        end
        expected_groups.push_back(g);
      end
      fdr_pkg::ACT_REFRESH: begin
        if (r0 >= 0 && r0 < fdr_pkg::SCREEN_HEIGHT) begin
          if (partial) begin
            sum = 16'hFFFF;
            for (int c = 0; c < fdr_pkg::SCREEN_WIDTH; c++) begin
              sum = crc8(sum, frame[r0 * fdr_pkg::SCREEN_WIDTH + c][15:8]);
              sum = crc8(sum, frame[r0 * fdr_pkg::SCREEN_WIDTH + c][7:0]);
            end
            if (sum == row_sums[r0]) return;
            row_sums[r0] = sum;
          end
          for (int b = 0; b < fdr_pkg::SCREEN_WIDTH; b += 4) begin
            g = '0;
            g.kind = fdr_pkg::KIND_ROW;
            g.row = r0[fdr_pkg::OUT_ROW_W-1:0];
            g.pa = frame[r0 * fdr_pkg::SCREEN_WIDTH + b];
            g.pb = frame[r0 * fdr_pkg::SCREEN_WIDTH + b + 1];
            g.pc = frame[r0 * fdr_pkg::SCREEN_WIDTH + b + 2];
            g.pd = frame[r0 * fdr_pkg::SCREEN_WIDTH + b + 3];
            g.last = (b + 4 >= fdr_pkg::SCREEN_WIDTH);
            expected_groups.push_back(g);
          end
        end
      end
      default: ;
    endcase
  endfunction

  always @(posedge clk) begin
    group_t want;
    if (rst) begin
      foreach (frame[i]) frame[i] = '0;
      foreach (row_sums[i]) row_sums[i] = '0;
      partial = 1'b1;
      expected_groups.delete();
      fail_count = 0;
    end else begin
      if (cfg_we) partial = cfg_data;
      if (out_valid && out_ready) begin
        if (expected_groups.size() == 0) begin
          report("unexpected result, row", 16'(row), 16'h0);
        end else begin
          want = expected_groups.pop_front();
          if (kind !== want.kind) report("kind", 16'(kind), 16'(want.kind));
          if (row !== want.row) report("row", 16'(row), 16'(want.row));
          if (pixel_a !== want.pa) report("pixel_a", pixel_a, want.pa);
          if (pixel_b !== want.pb) report("pixel_b", pixel_b, want.pb);
          if (pixel_c !== want.pc) report("pixel_c", pixel_c, want.pc);
          if (pixel_d !== want.pd) report("pixel_d", pixel_d, want.pd);
          if (last !== want.last) report("last", 16'(last), 16'(want.last));
        end
      end
      // Sampled values from before this edge, so the request reads the old frame.
      if (in_valid && in_ready)
        predict_request(action, int'(col_start), int'(col_end), int'(row_start),
                        int'(row_end), color, xor_mode);
    end
    pending = expected_groups.size();
  end
endmodule

// ===== tb/framebuffer_dirty_row_refresh_unit_tb.sv =====
// ----------------------------------------------------------------------------
// Frame store refresh testbench
// Drives draw, fill, read and row refresh requests in both refresh modes,
// directed corners first and then random sequences, with random idling.
// ----------------------------------------------------------------------------
module framebuffer_dirty_row_refresh_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STALL_LIMIT = 200000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic cfg_data = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [2:0] action = '0;
  logic signed [fdr_pkg::COORD_W-1:0] col_start = '0, col_end = '0;
  logic signed [fdr_pkg::COORD_W-1:0] row_start = '0, row_end = '0;
  logic [fdr_pkg::PIX_W-1:0] color = '0;
  logic xor_mode = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic kind, last;
  logic [fdr_pkg::OUT_ROW_W-1:0] row;
  logic [fdr_pkg::PIX_W-1:0] pixel_a, pixel_b, pixel_c, pixel_d;
  int fail_count, pending;
  int idle_cycles = 0;
  bit quiet = 1'b0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  framebuffer_dirty_row_refresh_unit dut (.*);
  framebuffer_dirty_row_refresh_unit_chk chk (.*);

  // Result side stalls at random except during the quiet stretch.
  always @(posedge clk) out_ready <= quiet || ($urandom_range(99) >= 13);

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // Valid stays high from one request to the next unless an idle cycle is drawn.
  task automatic send_request(input logic [2:0] op, input logic [8:0] c0, input logic [8:0] c1,
                              input logic [8:0] r0, input logic [8:0] r1,
                              input logic [15:0] clr, input logic xr);
    while (!quiet && $urandom_range(99) < 13) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    action <= op;
    col_start <= c0;
    col_end <= c1;
    row_start <= r0;
    row_end <= r1;
    color <= clr;
    xor_mode <= xr;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic set_mode(input logic mode);
    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    // Draw requests give no result, so wait long enough for a fill to finish.
    repeat (fdr_pkg::FS_DEPTH + 4 * fdr_pkg::SCREEN_WIDTH + 50) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_data <= mode;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [8:0] coord();
    case ($urandom_range(9))
      0: return 9'($urandom);
      1: return 9'($urandom_range(fdr_pkg::SCREEN_WIDTH + 8, fdr_pkg::SCREEN_WIDTH - 8));
      2: return 9'($urandom_range(3, 0) - 2);
      default: return 9'($urandom_range(fdr_pkg::SCREEN_WIDTH - 1));
    endcase
  endfunction

  task automatic random_request();
    logic [15:0] clr;
    int pick;
    clr = ($urandom_range(3) == 0) ? 16'($urandom_range(3)) : 16'($urandom);
    pick = $urandom_range(99);
    if (pick < 2) send_request(fdr_pkg::ACT_FILL, '0, '0, '0, '0, clr, 1'b0);
    else if (pick < 4) send_request(3'($urandom_range(7, 6)), coord(), coord(), coord(),
                                    coord(), clr, 1'($urandom));
    else if (pick < 25) send_request(fdr_pkg::ACT_PIXEL, coord(), coord(), coord(), coord(),
                                     clr, 1'($urandom));
    else if (pick < 45) send_request(fdr_pkg::ACT_HLINE, coord(), coord(), coord(), coord(),
                                     clr, 1'($urandom));
    else if (pick < 60) send_request(fdr_pkg::ACT_VLINE, coord(), coord(), coord(), coord(),
                                     clr, 1'($urandom));
    else if (pick < 75) send_request(fdr_pkg::ACT_READ, coord(), coord(), coord(), coord(),
                                     clr, 1'($urandom));
    else send_request(fdr_pkg::ACT_REFRESH, coord(), coord(), coord(), coord(), clr,
                      1'($urandom));
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed corners in partial mode.
    send_request(fdr_pkg::ACT_REFRESH, '0, '0, 9'd0, '0, '0, 1'b0);
    send_request(fdr_pkg::ACT_PIXEL, 9'd0, '0, 9'd0, '0, 16'hFFFF, 1'b0);
    send_request(fdr_pkg::ACT_PIXEL, 9'd127, '0, 9'd127, '0, 16'h8001, 1'b0);
    send_request(fdr_pkg::ACT_PIXEL, 9'h100, '0, 9'd5, '0, 16'h1234, 1'b0);
    send_request(fdr_pkg::ACT_PIXEL, 9'd128, '0, 9'h0FF, '0, 16'h1234, 1'b0);
    send_request(fdr_pkg::ACT_HLINE, 9'd200, 9'h1F0, 9'd3, '0, 16'hA5A5, 1'b0);
    send_request(fdr_pkg::ACT_HLINE, 9'd10, 9'd20, 9'd3, '0, 16'hA5A5, 1'b1);
    send_request(fdr_pkg::ACT_HLINE, 9'd0, 9'd127, 9'h1FF, '0, 16'h1111, 1'b0);
    send_request(fdr_pkg::ACT_HLINE, 9'h180, 9'h1FF, 9'd4, '0, 16'h1111, 1'b0);
    send_request(fdr_pkg::ACT_VLINE, 9'd7, '0, 9'd255, 9'h100, 16'h5A5A, 1'b1);
    send_request(fdr_pkg::ACT_VLINE, 9'd7, '0, 9'd0, 9'd127, 16'h5A5A, 1'b1);
    send_request(fdr_pkg::ACT_VLINE, 9'd128, '0, 9'd0, 9'd127, 16'h5A5A, 1'b0);
    send_request(fdr_pkg::ACT_READ, 9'd0, '0, 9'd0, '0, '0, 1'b0);
    send_request(fdr_pkg::ACT_READ, 9'd7, '0, 9'd3, '0, '0, 1'b0);
    send_request(fdr_pkg::ACT_READ, 9'h1FF, '0, 9'd3, '0, '0, 1'b0);
    send_request(fdr_pkg::ACT_REFRESH, '0, '0, 9'd3, '0, '0, 1'b0);
    send_request(fdr_pkg::ACT_REFRESH, '0, '0, 9'd3, '0, '0, 1'b0);
    send_request(fdr_pkg::ACT_REFRESH, '0, '0, 9'd127, '0, '0, 1'b0);
    send_request(fdr_pkg::ACT_REFRESH, '0, '0, 9'd128, '0, '0, 1'b0);
    send_request(fdr_pkg::ACT_REFRESH, '0, '0, 9'h100, '0, '0, 1'b0);
    send_request(3'd6, 9'd1, 9'd1, 9'd1, 9'd1, 16'hFFFF, 1'b1);
    send_request(3'd7, 9'd1, 9'd1, 9'd1, 9'd1, 16'hFFFF, 1'b1);
    send_request(fdr_pkg::ACT_FILL, '0, '0, '0, '0, 16'hF81F, 1'b0);
    send_request(fdr_pkg::ACT_REFRESH, '0, '0, 9'd64, '0, '0, 1'b0);

    set_mode(1'b0);
    send_request(fdr_pkg::ACT_REFRESH, '0, '0, 9'd64, '0, '0, 1'b0);
    send_request(fdr_pkg::ACT_REFRESH, '0, '0, 9'd64, '0, '0, 1'b0);

    // Random phases, each followed by a mode setting; one phase without idling.
    for (int phase = 0; phase < 4; phase++) begin
      quiet = (phase == 2);
      repeat (20) random_request();
      set_mode(phase[0]);
    end
    quiet = 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (fail_count == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end
endmodule
